@@ hw/rtl/sdbm_pkg.sv @@
package sdbm_pkg;

    localparam int unsigned CHANNELS     = 8;
    localparam int unsigned BUTTON_COUNT = 10;
    localparam int unsigned BTN_W        = $clog2(BUTTON_COUNT);
    localparam int unsigned TIME_W       = 32;
    localparam int unsigned DEBOUNCE_W   = 16;

    localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = DEBOUNCE_W'(50);

    localparam int unsigned COMBO_A     = 2;
    localparam int unsigned COMBO_B     = 7;
    localparam int unsigned CLEAR_COUNT = 9;

    localparam int unsigned SEQ_CH_A = 2;
    localparam int unsigned SEQ_CH_B = 3;
    localparam logic [BTN_W-1:0] SEQ_BTN_A = BTN_W'(8);
    localparam logic [BTN_W-1:0] SEQ_BTN_B = BTN_W'(9);

    typedef struct packed {
        logic accepted;
        logic level;
        logic stable;
    } sdbm_chan_evt_t;

    typedef struct packed {
        logic             hit;
        logic [BTN_W-1:0] btn;
    } sdbm_seq_t;

    function automatic sdbm_seq_t seq_target(input int unsigned ch);
        sdbm_seq_t r;
        r.hit = 1'b0;
        r.btn = '0;
        case (ch)
            SEQ_CH_A:
            begin
                r.hit = 1'b1;
                r.btn = SEQ_BTN_A;
            end
            SEQ_CH_B:
            begin
                r.hit = 1'b1;
                r.btn = SEQ_BTN_B;
            end
            default:
            begin
                r.hit = 1'b0;
            end
        endcase
        return r;
    endfunction

endpackage

@@ hw/rtl/shifter_debounce_button_mapper_unit.sv @@
// Debounces eight active-low switch channels and maps them to joystick buttons.
// Input channel (in_valid/in_ready): one scan per transaction, pin_levels with
//   bit i for channel i (0 means pressed) and the scan time now_ms in ms.
// Output channel (out_valid/out_ready): one result per scan, in order:
//   button_bits, report_strobe and sequential_on.
// Configuration: cfg_wr_en writes cfg_wr_data into the debounce time at the
//   clock edge; write it only while no scan is in flight.
// Pipeline: a scan accepted from the input channel waits in the input register;
//   its result is loaded into the output register once that register is empty
//   or being taken, and out_valid then rises.
// Throughput: one scan per cycle while out_ready is high. All channel timers,
//   button mapping and mode combo are combinational between the two registers.
// Stall: while out_ready is low the result holds; one more scan waits in the
//   input register, after which in_ready drops until the result is taken.
// Reset: all levels not pressed, timers zero, direct mode, buttons clear,
//   debounce time 50 ms; both registers empty.
module shifter_debounce_button_mapper_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [sdbm_pkg::CHANNELS-1:0]         pin_levels,
    input  logic [sdbm_pkg::TIME_W-1:0]           now_ms,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [sdbm_pkg::BUTTON_COUNT-1:0]     button_bits,
    output logic                                report_strobe,
    output logic                                sequential_on,
    input  logic                                cfg_wr_en,
    input  logic [sdbm_pkg::DEBOUNCE_W-1:0]       cfg_wr_data
);
    import sdbm_pkg::*;

    logic                    in_valid_reg;
    logic [CHANNELS-1:0]     pin_levels_reg;
    logic [TIME_W-1:0]       now_ms_reg;
    logic [DEBOUNCE_W-1:0]   debounce_reg;
    logic                    out_valid_reg;
    logic [BUTTON_COUNT-1:0] button_bits_reg;
    logic                    report_strobe_reg;
    logic                    sequential_on_reg;
    logic                    advance;
    sdbm_chan_evt_t          evt [CHANNELS];
    logic [BUTTON_COUNT-1:0] button_next;
    logic                    strobe_next;
    logic                    mode_next;

    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    for (genvar g = 0; g < CHANNELS; g++)
    begin : g_chan
        sdbm_chan u_chan (
            .clk         (clk),
            .rst_n       (rst_n),
            .pin_level   (pin_levels_reg[g]),
            .now_ms      (now_ms_reg),
            .debounce_ms (debounce_reg),
            .commit      (advance),
            .evt         (evt[g])
        );
    end

    sdbm_button_map u_map (
        .clk         (clk),
        .rst_n       (rst_n),
        .commit      (advance),
        .evt         (evt),
        .button_next (button_next),
        .strobe      (strobe_next),
        .mode_next   (mode_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg <= DEBOUNCE_RESET;
        end
        else if (cfg_wr_en)
        begin
            debounce_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            pin_levels_reg <= pin_levels;
            now_ms_reg     <= now_ms;
        end
        if (advance)
        begin
            button_bits_reg   <= button_next;
            report_strobe_reg <= strobe_next;
            sequential_on_reg <= mode_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign button_bits   = button_bits_reg;
    assign report_strobe = report_strobe_reg;
    assign sequential_on = sequential_on_reg;

endmodule

@@ hw/rtl/sdbm_chan.sv @@
module sdbm_chan (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          pin_level,
    input  logic [sdbm_pkg::TIME_W-1:0]     now_ms,
    input  logic [sdbm_pkg::DEBOUNCE_W-1:0] debounce_ms,
    input  logic                          commit,
    output sdbm_pkg::sdbm_chan_evt_t        evt
);
    import sdbm_pkg::*;

    logic              prev_reg;
    logic              stable_reg;
    logic [TIME_W-1:0] change_time_reg;
    logic [TIME_W-1:0] change_time_next;
    logic [TIME_W-1:0] elapsed;
    logic              reading;

    assign reading          = ~pin_level;
    assign change_time_next = (reading != prev_reg) ? now_ms : change_time_reg;
    assign elapsed          = now_ms - change_time_next;

    always_comb
    begin
        evt.accepted = (elapsed > {{(TIME_W-DEBOUNCE_W){1'b0}}, debounce_ms})
                       && (reading != stable_reg);
        evt.level    = reading;
        evt.stable   = evt.accepted ? reading : stable_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg        <= 1'b0;
            stable_reg      <= 1'b0;
            change_time_reg <= '0;
        end
        else if (commit)
        begin
            prev_reg        <= reading;
            stable_reg      <= evt.stable;
            change_time_reg <= change_time_next;
        end
    end

endmodule

@@ hw/rtl/sdbm_button_map.sv @@
module sdbm_button_map (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              commit,
    input  sdbm_pkg::sdbm_chan_evt_t            evt [sdbm_pkg::CHANNELS],
    output logic [sdbm_pkg::BUTTON_COUNT-1:0]   button_next,
    output logic                              strobe,
    output logic                              mode_next
);
    import sdbm_pkg::*;

    logic [BUTTON_COUNT-1:0] buttons_reg;
    logic                    mode_reg;
    logic                    seen_first_reg;
    logic                    seen_second_reg;
    logic                    seen_first_next;
    logic                    seen_second_next;
    logic                    combo_a;
    logic                    combo_b;

    assign combo_a = evt[COMBO_A].stable;
    assign combo_b = evt[COMBO_B].stable;

    always_comb
    begin
        sdbm_seq_t seq;
        button_next      = buttons_reg;
        strobe           = 1'b0;
        mode_next        = mode_reg;
        seen_first_next  = seen_first_reg;
        seen_second_next = seen_second_reg;
        seq              = '0;
        for (int unsigned i = 0; i < CHANNELS; i++)
        begin
            if (evt[i].accepted)
            begin
                if (mode_reg)
                begin
                    button_next[i] = 1'b0;
                    seq = seq_target(i);
                    if (seq.hit)
                    begin
                        button_next[seq.btn] = evt[i].level;
                        strobe = 1'b1;
                    end
                end
                else
                begin
                    button_next[i] = evt[i].level;
                    strobe = 1'b1;
                end
            end
        end
        if ((combo_a != seen_first_reg) && (combo_b != seen_second_reg))
        begin
            if (combo_a && combo_b)
            begin
                mode_next = ~mode_reg;
                for (int unsigned n = 0; n < CLEAR_COUNT; n++)
                begin
                    button_next[n] = 1'b0;
                end
            end
            seen_first_next  = combo_a;
            seen_second_next = combo_b;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buttons_reg     <= '0;
            mode_reg        <= 1'b0;
            seen_first_reg  <= 1'b0;
            seen_second_reg <= 1'b0;
        end
        else if (commit)
        begin
            buttons_reg     <= button_next;
            mode_reg        <= mode_next;
            seen_first_reg  <= seen_first_next;
            seen_second_reg <= seen_second_next;
        end
    end

endmodule
